// File: sv/pafw_pkg.sv
package pafw_pkg;

  localparam int unsigned FracBits     = 16;
  localparam int unsigned MaxTransforms = 4;
  localparam int unsigned GridDim      = 8;
  localparam int unsigned WordsPerTri  = 6;
  localparam int unsigned TrisPerCell  = 4;
  localparam int unsigned TableDepth   =
    MaxTransforms * WordsPerTri * TrisPerCell * GridDim * GridDim;
  // one bank per affine word, so all words of a triangle are read together
  localparam int unsigned BankDepth    = TableDepth / WordsPerTri;
  localparam int unsigned BankAw       = $clog2(BankDepth);
  // reciprocal of six for a 13-bit table address (exact below 8192)
  localparam logic [13:0] RecipSix     = 14'd10923;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    CFG_CELLS_X     = 3'd0,
    CFG_CELLS_Y     = 3'd1,
    CFG_CELL_WIDTH  = 3'd2,
    CFG_CELL_HEIGHT = 3'd3,
    CFG_INV_WIDTH   = 3'd4,
    CFG_INV_HEIGHT  = 3'd5,
    CFG_STEPS       = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic               operation;
    logic [12:0]        table_index;
    logic signed [31:0] coefficient_value;
    logic [1:0]         transform_index;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // table word write
    logic start;    // take point, transformation base and grid extents
    logic loc1;     // scale into cell units
    logic loc2;     // clamp, pick triangle, form bank address
    logic mem;      // bank read
    logic mul;      // affine products
    logic upd;      // sums, saturation, new point
    logic capture;  // point into output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [7:0] solver_steps;
  } stat_t;

  // grid size with zero read as one and large values limited to the grid
  function automatic logic [3:0] grid_count(input logic [3:0] c);
    logic [3:0] r;
    if (c == 4'd0) begin
      r = 4'd1;
    end else if (c > 4'(GridDim)) begin
      r = 4'(GridDim);
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

// File: sv/pafw_ram.sv
module pafw_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/pafw_datapath.sv
module pafw_datapath
  import pafw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [30:0] cfg_wdata_i,
  input  in_t         in_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output out_t        out_o
);

  // configuration registers
  logic [3:0]  cells_x_q, cells_y_q;
  logic [30:0] cell_w_q, cell_h_q, inv_w_q, inv_h_q;
  logic [7:0]  steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cells_x_q <= 4'd4;
      cells_y_q <= 4'd4;
      cell_w_q  <= 31'd32768;
      cell_h_q  <= 31'd32768;
      inv_w_q   <= 31'd131072;
      inv_h_q   <= 31'd131072;
      steps_q   <= 8'd50;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_CELLS_X:     cells_x_q <= cfg_wdata_i[3:0];
        CFG_CELLS_Y:     cells_y_q <= cfg_wdata_i[3:0];
        CFG_CELL_WIDTH:  cell_w_q  <= cfg_wdata_i;
        CFG_CELL_HEIGHT: cell_h_q  <= cfg_wdata_i;
        CFG_INV_WIDTH:   inv_w_q   <= cfg_wdata_i;
        CFG_INV_HEIGHT:  inv_h_q   <= cfg_wdata_i;
        CFG_STEPS:       steps_q   <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign stat_o.solver_steps = steps_q;

  // load address split into bank row and bank number
  logic [26:0]       ld_prod;
  logic [BankAw-1:0] ld_row;
  logic [15:0]       ld_rem_full;
  logic [2:0]        ld_bank;
  logic              ld_ok;

  assign ld_prod     = 27'(in_i.table_index) * 27'(RecipSix);
  assign ld_row      = ld_prod[16+:BankAw];
  assign ld_rem_full = 16'(in_i.table_index) - 16'(ld_row) * 16'(WordsPerTri);
  assign ld_bank     = ld_rem_full[2:0];
  assign ld_ok       = (32'(in_i.table_index) < 32'(TableDepth));

  // per point state
  logic [3:0]         ncx_q, ncy_q;
  logic [BankAw-1:0]  base_q;
  logic [34:0]        wx_q, hy_q;
  logic signed [31:0] x_q, y_q;
  logic [3:0]         ncx_d, ncy_d;
  logic [7:0]         area_d;

  assign ncx_d  = grid_count(cells_x_q);
  assign ncy_d  = grid_count(cells_y_q);
  assign area_d = 8'(ncx_d) * 8'(ncy_d);

  // scale into cell units
  logic signed [32:0] px_q, py_q, px_d, py_d;
  logic signed [47:0] ux_q, uy_q;
  logic signed [64:0] prx, pry;

  assign px_d = 33'(x_q) + 33'sd65536;
  assign py_d = 33'(y_q) + 33'sd65536;
  assign prx  = 65'(px_d) * $signed({34'd0, inv_w_q});
  assign pry  = 65'(py_d) * $signed({34'd0, inv_h_q});

  // clamp and triangle choice
  logic signed [49:0] uxe, uye, gxe, gye;
  logic [19:0]        cx, cy;
  logic [15:0]        fx, fy;
  logic [16:0]        one_m_fx;
  logic signed [35:0] pxe, pye, wxe, hye;
  logic               px_lo, px_hi, py_lo, py_hi, lo_diag, hi_diag;
  logic [1:0]         tri_sel;
  logic [5:0]         grid_pos;
  logic [BankAw-1:0]  row_d, row_q;

  assign uxe = 50'(ux_q);
  assign uye = 50'(uy_q);
  assign gxe = $signed({30'd0, ncx_q, 16'd0});
  assign gye = $signed({30'd0, ncy_q, 16'd0});
  assign pxe = 36'(px_q);
  assign pye = 36'(py_q);
  assign wxe = $signed({1'b0, wx_q});
  assign hye = $signed({1'b0, hy_q});

  always_comb begin
    if (uxe < 0) begin
      cx = '0;
    end else if (uxe > gxe - 50'sd1) begin
      cx = 20'(gxe - 50'sd1);
    end else begin
      cx = ux_q[19:0];
    end
    if (uye < 0) begin
      cy = '0;
    end else if (uye > gye - 50'sd1) begin
      cy = 20'(gye - 50'sd1);
    end else begin
      cy = uy_q[19:0];
    end
  end

  assign fx       = cx[15:0];
  assign fy       = cy[15:0];
  assign one_m_fx = 17'd65536 - 17'(fx);
  assign px_lo    = (pxe <= 0);
  assign px_hi    = (pxe >= wxe);
  assign py_lo    = (pye <= 0);
  assign py_hi    = (pye >= hye);

  // diagonal tests used outside the grid, left or right side
  always_comb begin
    if (px_lo) begin
      lo_diag = (uye < uxe);
      hi_diag = (uye - gye > -uxe);
    end else begin
      lo_diag = (-uye > uxe - gxe);
      hi_diag = (uye - gye > uxe - gxe);
    end
  end

  always_comb begin
    priority if (px_lo || px_hi) begin
      if (py_lo && lo_diag) begin
        tri_sel = 2'd0;
      end else if (py_hi && hi_diag) begin
        tri_sel = 2'd2;
      end else begin
        tri_sel = px_lo ? 2'd3 : 2'd1;
      end
    end else if (py_lo) begin
      tri_sel = 2'd0;
    end else if (py_hi) begin
      tri_sel = 2'd2;
    end else if (fx < fy) begin
      tri_sel = (one_m_fx < 17'(fy)) ? 2'd2 : 2'd3;
    end else if (one_m_fx < 17'(fy)) begin
      tri_sel = 2'd1;
    end else begin
      tri_sel = 2'd0;
    end
  end

  assign grid_pos = 6'(cx[18:16]) + 6'(7'(cy[18:16]) * 7'(ncx_q));
  assign row_d    = base_q + BankAw'({grid_pos, 2'b00}) + BankAw'(tri_sel);

  // coefficient banks
  logic [31:0] rdata [WordsPerTri];

  for (genvar b = 0; b < WordsPerTri; b++) begin : g_bank
    pafw_ram #(
      .Width(32),
      .Depth(BankDepth)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (cmd_i.load && ld_ok && (ld_bank == 3'(b))),
      .waddr_i(ld_row),
      .wdata_i(in_i.coefficient_value),
      .re_i   (cmd_i.mem),
      .raddr_i(row_q),
      .rdata_o(rdata[b])
    );
  end

  // affine products
  logic signed [47:0] p0_q, p1_q, p3_q, p4_q;
  logic signed [31:0] c2_q, c5_q;
  logic signed [63:0] m0, m1, m3, m4;

  assign m0 = $signed(rdata[0]) * x_q;
  assign m1 = $signed(rdata[1]) * y_q;
  assign m3 = $signed(rdata[3]) * x_q;
  assign m4 = $signed(rdata[4]) * y_q;

  // sums with saturation
  logic signed [49:0] nx, ny;
  logic signed [31:0] nx_sat, ny_sat;

  assign nx = 50'(p0_q) + 50'(p1_q) + 50'(c2_q);
  assign ny = 50'(p3_q) + 50'(p4_q) + 50'(c5_q);

  always_comb begin
    if (nx > 50'sd2147483647) begin
      nx_sat = 32'sh7fffffff;
    end else if (nx < -50'sd2147483648) begin
      nx_sat = 32'sh80000000;
    end else begin
      nx_sat = nx[31:0];
    end
    if (ny > 50'sd2147483647) begin
      ny_sat = 32'sh7fffffff;
    end else if (ny < -50'sd2147483648) begin
      ny_sat = 32'sh80000000;
    end else begin
      ny_sat = ny[31:0];
    end
  end

  // datapath registers
  out_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q    <= in_i.point_x;
      y_q    <= in_i.point_y;
      ncx_q  <= ncx_d;
      ncy_q  <= ncy_d;
      base_q <= BankAw'(10'(in_i.transform_index) * 10'({area_d, 2'b00}));
      wx_q   <= 35'(ncx_d) * 35'(cell_w_q);
      hy_q   <= 35'(ncy_d) * 35'(cell_h_q);
    end
    if (cmd_i.loc1) begin
      px_q <= px_d;
      py_q <= py_d;
      ux_q <= prx[63:16];
      uy_q <= pry[63:16];
    end
    if (cmd_i.loc2) begin
      row_q <= row_d;
    end
    if (cmd_i.mul) begin
      p0_q <= m0[63:16];
      p1_q <= m1[63:16];
      p3_q <= m3[63:16];
      p4_q <= m4[63:16];
      c2_q <= $signed(rdata[2]);
      c5_q <= $signed(rdata[5]);
    end
    if (cmd_i.upd) begin
      x_q <= nx_sat;
      y_q <= ny_sat;
    end
    if (cmd_i.capture) begin
      out_q.new_x <= x_q;
      out_q.new_y <= y_q;
    end
  end

  assign out_o = out_q;

endmodule

// File: sv/pafw_ctrl.sv
module pafw_ctrl
  import pafw_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  logic  in_op_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOC1,
    ST_LOC2,
    ST_MEM,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       in_acc, out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_op_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            cnt_d       = stat_i.solver_steps;
            state_d     = (stat_i.solver_steps == 8'd0) ? ST_DONE : ST_LOC1;
          end
        end
      end
      ST_LOC1: begin
        cmd_o.loc1 = 1'b1;
        state_d    = ST_LOC2;
      end
      ST_LOC2: begin
        cmd_o.loc2 = 1'b1;
        state_d    = ST_MEM;
      end
      ST_MEM: begin
        cmd_o.mem = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        cnt_d     = cnt_q - 8'd1;
        state_d   = (cnt_q == 8'd1) ? ST_DONE : ST_LOC1;
      end
      ST_DONE: begin
        // wait for the output register to be free
        if (out_free) begin
          cmd_o.capture = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: sv/piecewise_affine_point_warp_unit.sv
// Load transaction: the word is written at acceptance.
// Point transaction: each solver step runs scale, locate, bank read,
// products and update in turn; the result is captured after the last step.
// A new transaction is accepted only while idle; a waiting result delays
// the next capture and so the next acceptance. Reset (rst_ni, asynchronous,
// low) clears control and restores register defaults; the coefficient banks are not cleared.
module piecewise_affine_point_warp_unit
  import pafw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o
);

  cmd_t  cmd;
  stat_t stat;

  pafw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_op_i    (in_i.operation),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pafw_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_o      (out_o)
  );

endmodule
